// ----- rtl/core/bbe_pkg.sv -----
// Shared types, constants and the averaging divider for the 3x3 edge-normalised box blur.
package bbe_pkg;

    // Frame limits and derived widths
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIM_W      = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
    localparam int OROW_W     = $clog2(MAX_HEIGHT);
    localparam int CFG_IDX_W  = 2;

    // Sum widths: one column of three pixels, then three columns
    localparam int COLSUM_W   = 10;
    localparam int SUM_W      = 12;

    // Reciprocals for truncating division, exact for sums up to 9 * 255
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(10923);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } out_item_t;

    // One window column: row above, centre row, row below
    typedef struct packed {
        rgb_t upper;
        rgb_t centre;
        rgb_t lower;
    } column_t;

    // One line store entry: the two rows held for each column
    typedef struct packed {
        rgb_t older;
        rgb_t newer;
    } line_pair_t;

    typedef struct packed {
        logic [COLSUM_W-1:0] red;
        logic [COLSUM_W-1:0] green;
        logic [COLSUM_W-1:0] blue;
    } col_sums_t;

    // Per-item control from the frame counters
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             in_frame;
        logic             emit;
        logic             top;
        logic             bottom;
        logic             at_left;
        logic             at_right;
        logic             last;
    } item_flags_t;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } divisor_t;

    // Truncating average of a window sum
    function automatic logic [7:0] avg_div(input logic [SUM_W-1:0] sum, input divisor_t div);
        logic [SUM_W+RECIP_W-1:0] prod;
        logic [7:0]               q;
        prod = '0;
        q    = '0;
        unique case (div)
            DIV_BY_4:
            begin
                q = sum[9:2];
            end
            DIV_BY_6:
            begin
                prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_6);
                q    = prod[RECIP_SHIFT +: 8];
            end
            DIV_BY_9:
            begin
                prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_9);
                q    = prod[RECIP_SHIFT +: 8];
            end
            default:
            begin
                q = '0;
            end
        endcase
        return q;
    endfunction

endpackage

// ----- rtl/core/bbe_line_store.sv -----
// Two-row line store: one registered read and one write per cycle.
module bbe_line_store (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [bbe_pkg::COL_W-1:0] rd_addr,
    output bbe_pkg::line_pair_t       rd_data,
    input  logic                      wr_en,
    input  logic [bbe_pkg::COL_W-1:0] wr_addr,
    input  bbe_pkg::line_pair_t       wr_data
);
    import bbe_pkg::*;

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rd_data_reg;

    // Read the two rows above the incoming pixel
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Shift the column down by one row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/bbe_column_cell.sv -----
// One window column cell: holds a column, passes it on, and sums its in-image rows.
module bbe_column_cell (
    input  logic                 clk,
    input  logic                 shift,
    input  bbe_pkg::column_t     col_in,
    input  logic                 top,
    input  logic                 bottom,
    input  logic                 use_col,
    output bbe_pkg::column_t     col_out,
    output bbe_pkg::col_sums_t   sums
);
    import bbe_pkg::*;

    column_t col_reg;

    // Take the neighbour's column on every transaction
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    // Sum the rows that lie inside the image
    always_comb
    begin
        sums = '0;
        if (use_col)
        begin
            sums.red   = COLSUM_W'(col_reg.centre.red);
            sums.green = COLSUM_W'(col_reg.centre.green);
            sums.blue  = COLSUM_W'(col_reg.centre.blue);
            if (top)
            begin
                sums.red   = sums.red   + COLSUM_W'(col_reg.upper.red);
                sums.green = sums.green + COLSUM_W'(col_reg.upper.green);
                sums.blue  = sums.blue  + COLSUM_W'(col_reg.upper.blue);
            end
            if (bottom)
            begin
                sums.red   = sums.red   + COLSUM_W'(col_reg.lower.red);
                sums.green = sums.green + COLSUM_W'(col_reg.lower.green);
                sums.blue  = sums.blue  + COLSUM_W'(col_reg.lower.blue);
            end
        end
    end

    assign col_out = col_reg;

endmodule

// ----- rtl/core/bbe_frame_ctrl.sv -----
// Frame size registers and the input/output position counters.
module bbe_frame_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          cfg_write,
    input  logic [bbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbe_pkg::DIM_W-1:0]     cfg_data,
    output bbe_pkg::item_flags_t          flags
);
    import bbe_pkg::*;

    logic [DIM_W-1:0]  frame_width_reg, frame_width_next;
    logic [DIM_W-1:0]  frame_height_reg, frame_height_next;
    logic [COL_W-1:0]  in_column_reg, in_column_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_column_reg, out_column_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  col_inc;
    logic [DIM_W-1:0]  out_col_inc;
    logic [DIM_W-1:0]  out_row_inc;

    // Clamp the frame size to the supported range
    always_comb
    begin
        if (frame_width_reg < DIM_W'(2))
            w = DIM_W'(2);
        else if (frame_width_reg > DIM_W'(MAX_WIDTH))
            w = DIM_W'(MAX_WIDTH);
        else
            w = frame_width_reg;
        if (frame_height_reg < DIM_W'(2))
            h = DIM_W'(2);
        else if (frame_height_reg > DIM_W'(MAX_HEIGHT))
            h = DIM_W'(MAX_HEIGHT);
        else
            h = frame_height_reg;
    end

    // Classify the current transaction from the counters
    always_comb
    begin
        out_col_inc    = DIM_W'(out_column_reg) + DIM_W'(1);
        out_row_inc    = DIM_W'(out_row_reg) + DIM_W'(1);
        flags.col      = (DIM_W'(in_column_reg) < w) ? in_column_reg : '0;
        flags.in_frame = DIM_W'(in_row_reg) < h;
        flags.emit     = (in_row_reg >= ROW_W'(2)) ||
                         ((in_row_reg == ROW_W'(1)) && (in_column_reg != '0));
        flags.top      = out_row_reg != '0;
        flags.bottom   = out_row_inc < h;
        flags.at_right = out_col_inc >= w;
        flags.at_left  = out_column_reg == '0;
        flags.last     = flags.emit && !flags.bottom && flags.at_right;
        col_inc        = DIM_W'(flags.col) + DIM_W'(1);
    end

    // Advance the counters; restart the frame after its last result or a frame size register write
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        in_column_next    = in_column_reg;
        in_row_next       = in_row_reg;
        out_column_next   = out_column_reg;
        out_row_next      = out_row_reg;
        if (cfg_write)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                frame_width_next = cfg_data;
                in_column_next   = '0;
                in_row_next      = '0;
                out_column_next  = '0;
                out_row_next     = '0;
            end
            else if (cfg_index == REG_FRAME_HEIGHT)
            begin
                frame_height_next = cfg_data;
                in_column_next    = '0;
                in_row_next       = '0;
                out_column_next   = '0;
                out_row_next      = '0;
            end
        end
        else if (accept)
        begin
            if (col_inc >= w)
            begin
                in_column_next = '0;
                in_row_next    = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_column_next = col_inc[COL_W-1:0];
            end
            if (flags.emit)
            begin
                if (flags.at_right)
                begin
                    out_column_next = '0;
                    out_row_next    = out_row_inc[OROW_W-1:0];
                end
                else
                begin
                    out_column_next = out_col_inc[COL_W-1:0];
                end
            end
            if (flags.last)
            begin
                in_column_next  = '0;
                in_row_next     = '0;
                out_column_next = '0;
                out_row_next    = '0;
            end
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(MAX_WIDTH);
            frame_height_reg <= DIM_W'(MAX_HEIGHT);
            in_column_reg    <= '0;
            in_row_reg       <= '0;
            out_column_reg   <= '0;
            out_row_reg      <= '0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_column_reg    <= in_column_next;
            in_row_reg       <= in_row_next;
            out_column_reg   <= out_column_next;
            out_row_reg      <= out_row_next;
        end
    end

endmodule

// ----- rtl/core/box_blur_3x3_edge_normalized.sv -----
// Top level of the streaming 3x3 edge-normalised RGB box blur. Takes one raster-order pixel
// per clock and gives one blurred pixel per clock unless stalled; each result passes stages
// 1-3 and the output register after the transaction that completes its neighbourhood, which
// is the pixel one row and one column after it, so a frame needs width+1 drain transactions
// after its last pixel, and its final result carries frame_end. The rate is set by the line
// store, which takes one read and one write every cycle, and by a three-cell column chain
// that shifts once per transaction. An output skid register lets one finished result wait
// while the next one arrives; pixel_stall rises only when that skid register is full.
// Writing frame_width or frame_height restarts the frame; write them while the block is idle.
module box_blur_3x3_edge_normalized (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  bbe_pkg::in_item_t             pixel_item,
    output logic                          blur_valid,
    input  logic                          blur_stall,
    output bbe_pkg::out_item_t            blur_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbe_pkg::DIM_W-1:0]     cfg_data
);
    import bbe_pkg::*;

    logic        advance;
    logic        accept;
    logic        cfg_write;
    item_flags_t flags;
    rgb_t        pix;

    logic        s1_valid_reg;
    item_flags_t s1_flags_reg;
    rgb_t        s1_pix_reg;
    line_pair_t  rd_data;
    line_pair_t  wr_data;
    logic        wr_en;
    logic        shift;
    column_t     new_col;
    column_t     col0, col1, col2;
    col_sums_t   sums0, sums1, sums2;

    logic        s2_valid_reg;
    item_flags_t s2_flags_reg;

    logic             s3_valid_reg;
    logic [SUM_W-1:0] s3_red_reg, s3_green_reg, s3_blue_reg;
    divisor_t         s3_div_reg;
    logic             s3_last_reg;
    divisor_t         div_sel;

    out_item_t   result;
    logic        incoming;
    logic        out_free;
    logic        out_valid_reg;
    out_item_t   out_reg;
    logic        skid_valid_reg;
    out_item_t   skid_reg;

    // Handshakes: the pipeline freezes only while the skid register is full
    assign advance     = !skid_valid_reg;
    assign pixel_stall = skid_valid_reg;
    assign accept      = pixel_valid && advance;
    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;

    bbe_frame_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flags     (flags)
    );

    // Drop the channels of drain transactions
    always_comb
    begin
        pix = '0;
        if (flags.in_frame)
        begin
            pix.red   = pixel_item.in_red;
            pix.green = pixel_item.in_green;
            pix.blue  = pixel_item.in_blue;
        end
    end

    // Stage 1: hold the transaction while the line store is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= flags;
            s1_pix_reg   <= pix;
        end
    end

    assign wr_en         = advance && s1_valid_reg && s1_flags_reg.in_frame;
    assign wr_data.older = rd_data.newer;
    assign wr_data.newer = s1_pix_reg;

    bbe_line_store u_lines (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (flags.col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_flags_reg.col),
        .wr_data (wr_data)
    );

    // Window: the new column enters cell 2 and moves towards cell 0
    assign shift          = advance && s1_valid_reg;
    assign new_col.upper  = rd_data.older;
    assign new_col.centre = rd_data.newer;
    assign new_col.lower  = s1_pix_reg;

    bbe_column_cell u_cell2 (
        .clk     (clk),
        .shift   (shift),
        .col_in  (new_col),
        .top     (s2_flags_reg.top),
        .bottom  (s2_flags_reg.bottom),
        .use_col (!s2_flags_reg.at_right),
        .col_out (col2),
        .sums    (sums2)
    );

    bbe_column_cell u_cell1 (
        .clk     (clk),
        .shift   (shift),
        .col_in  (col2),
        .top     (s2_flags_reg.top),
        .bottom  (s2_flags_reg.bottom),
        .use_col (1'b1),
        .col_out (col1),
        .sums    (sums1)
    );

    bbe_column_cell u_cell0 (
        .clk     (clk),
        .shift   (shift),
        .col_in  (col1),
        .top     (s2_flags_reg.top),
        .bottom  (s2_flags_reg.bottom),
        .use_col (!s2_flags_reg.at_left),
        .col_out (col0),
        .sums    (sums0)
    );

    // Stage 2: flags of the result that the shifted window now holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg && s1_flags_reg.emit;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
            s2_flags_reg <= s1_flags_reg;
    end

    // Pick the divisor from how many rows and columns lie in the image
    always_comb
    begin
        if (s2_flags_reg.top && s2_flags_reg.bottom)
            div_sel = (s2_flags_reg.at_left || s2_flags_reg.at_right) ? DIV_BY_6 : DIV_BY_9;
        else
            div_sel = (s2_flags_reg.at_left || s2_flags_reg.at_right) ? DIV_BY_4 : DIV_BY_6;
    end

    // Stage 3: window sums per channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (advance)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_red_reg   <= SUM_W'(sums0.red) + SUM_W'(sums1.red) + SUM_W'(sums2.red);
            s3_green_reg <= SUM_W'(sums0.green) + SUM_W'(sums1.green) + SUM_W'(sums2.green);
            s3_blue_reg  <= SUM_W'(sums0.blue) + SUM_W'(sums1.blue) + SUM_W'(sums2.blue);
            s3_div_reg   <= div_sel;
            s3_last_reg  <= s2_flags_reg.last;
        end
    end

    // Divide into the averages
    always_comb
    begin
        result.out_red   = avg_div(s3_red_reg, s3_div_reg);
        result.out_green = avg_div(s3_green_reg, s3_div_reg);
        result.out_blue  = avg_div(s3_blue_reg, s3_div_reg);
        result.frame_end = s3_last_reg;
    end

    // Output register with skid: park a result that arrives while the output is stalled
    assign incoming = advance && s3_valid_reg;
    assign out_free = !out_valid_reg || !blur_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || incoming;
            skid_valid_reg <= 1'b0;
        end
        else if (incoming)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (incoming)
                out_reg <= result;
        end
        else if (incoming)
        begin
            skid_reg <= result;
        end
    end

    assign blur_valid = out_valid_reg;
    assign blur_item  = out_reg;

endmodule
